// ===== hw/rtl/ssis_pkg.sv =====
// Shared types and constants for the sorted set insert/search core.
// No dependencies; imported by every module of the core.
package ssis_pkg;

  localparam int DEPTH     = 1024;
  localparam int KEY_BITS  = 16;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int POS_BITS  = 10;
  localparam int STAT_BITS = 3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [STAT_BITS-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } ssis_status_t;

  typedef struct packed {
    logic                action;
    logic [KEY_BITS-1:0] key;
  } ssis_req_t;

  typedef struct packed {
    ssis_status_t        status;
    logic [POS_BITS-1:0] position;
    logic [CNT_BITS-1:0] count;
  } ssis_rsp_t;

  // One write port and one read port into the key store.
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [KEY_BITS-1:0]  wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } ssis_mem_req_t;

endpackage

// ===== hw/rtl/ssis_store.sv =====
// Key store: DEPTH x KEY_BITS memory, one write and one registered read per cycle.
// Depends on ssis_pkg.
module ssis_store (
  input  logic                          clk,
  input  ssis_pkg::ssis_mem_req_t       mem_req,
  output logic [ssis_pkg::KEY_BITS-1:0] rd_data
);
  import ssis_pkg::*;

  logic [KEY_BITS-1:0] mem [DEPTH];
  logic [KEY_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ssis_ctrl.sv =====
// Sequencer: binary search over the store, shift-up on insert, result register.
// Depends on ssis_pkg; drives ssis_store through one ssis_mem_req_t.
module ssis_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ssis_pkg::ssis_req_t           in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ssis_pkg::ssis_rsp_t           out_rsp,
  output ssis_pkg::ssis_mem_req_t       mem_req,
  input  logic [ssis_pkg::KEY_BITS-1:0] rd_data
);
  import ssis_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_CMP, S_SHIFT, S_PUT, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic                 act_r, act_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [CNT_BITS-1:0]  lo_r, lo_nxt;
  logic [CNT_BITS-1:0]  hi_r, hi_nxt;
  logic [CNT_BITS-1:0]  mid_r, mid_nxt;
  logic [CNT_BITS-1:0]  slot_r, slot_nxt;
  logic [CNT_BITS-1:0]  sh_r, sh_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_BITS-1:0] pend_addr_r, pend_addr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  ssis_status_t         res_st_r, res_st_nxt;
  logic [POS_BITS-1:0]  res_pos_r, res_pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ssis_rsp_t            out_rsp_r, out_rsp_nxt;
  logic [CNT_BITS-1:0]  mid;
  logic [CNT_BITS-1:0]  sh_dec;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign sh_dec = sh_r - CNT_BITS'(1);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    slot_nxt      = slot_r;
    sh_nxt        = sh_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    count_nxt     = count_r;
    res_st_nxt    = res_st_r;
    res_pos_nxt   = res_pos_r;
    out_rsp_nxt   = out_rsp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_req.action;
          key_nxt   = in_req.key;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = mid[ADDR_BITS-1:0];
          mid_nxt       = mid;
          state_nxt     = S_CMP;
        end else begin
          // miss: lo is the insertion slot
          slot_nxt    = lo_r;
          res_pos_nxt = '0;
          state_nxt   = S_DONE;
          if (act_r == ACT_SEARCH) begin
            res_st_nxt = ST_NOT_FOUND;
          end else if (count_r == CNT_BITS'(DEPTH)) begin
            res_st_nxt = ST_FULL;
          end else begin
            res_st_nxt  = ST_INSERTED;
            res_pos_nxt = POS_BITS'(lo_r);
            sh_nxt      = count_r;
            pend_nxt    = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end
      end
      S_CMP: begin
        if (rd_data == key_r) begin
          slot_nxt  = mid_r;
          state_nxt = S_DONE;
          if (act_r == ACT_SEARCH) begin
            res_st_nxt  = ST_FOUND;
            res_pos_nxt = POS_BITS'(mid_r);
          end else begin
            res_st_nxt  = ST_DUPLICATE;
            res_pos_nxt = '0;
          end
        end else begin
          if (rd_data < key_r) begin
            lo_nxt = mid_r + CNT_BITS'(1);
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_SRCH;
        end
      end
      S_SHIFT: begin
        // write back the entry read last cycle, one slot higher
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_addr_r;
          mem_req.wdata = rd_data;
        end
        if (sh_r > slot_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = sh_dec[ADDR_BITS-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = sh_r[ADDR_BITS-1:0];
          sh_nxt        = sh_dec;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slot_r[ADDR_BITS-1:0];
        mem_req.wdata = key_r;
        count_nxt     = count_r + CNT_BITS'(1);
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_rsp_nxt.status   = res_st_r;
          out_rsp_nxt.position = res_pos_r;
          out_rsp_nxt.count    = count_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    slot_r      <= slot_nxt;
    sh_r        <= sh_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_st_r    <= res_st_nxt;
    res_pos_r   <= res_pos_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // entry count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("entry count above capacity");

  // the search phase never writes the store
  a_search_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_CMP) |-> !mem_req.we)
    else $error("store written during search");

  // shift writes land strictly above the insertion slot
  a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && mem_req.we) |-> (CNT_BITS'(mem_req.waddr) > slot_r))
    else $error("shift write at or below slot");

  // count only moves on the final key write
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PUT) |=> (count_r == $past(count_r)))
    else $error("count changed outside key write");

  // an accepted request starts the search next cycle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SRCH))
    else $error("request not followed by search");

endmodule

// ===== hw/rtl/sorted_set_insert_search_core.sv =====
// Top level of the sorted set insert/search core.
// Depends on ssis_pkg, ssis_store and ssis_ctrl.
//
//  channel | handshake            | payload                        | direction
//  --------+----------------------+--------------------------------+----------
//  in_     | in_valid / in_ready  | in_req  (action, key)          | input
//  out_    | out_valid / out_ready| out_rsp (status, position, cnt)| output
//
// One request at a time. Each binary-search probe is a memory read, then a
// compare. An insert then shifts up the entries above the slot: the shift-up
// streams one entry per cycle through the single-read, single-write port
// store, then the key write.
// Synchronous active-low reset clears the entry count and the control; the
// store contents are not cleared, entries at or above the count are never read.
// The result sits in an output register; a new request is taken while it
// waits, and the next result is held back until the earlier one is taken.
module sorted_set_insert_search_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssis_pkg::ssis_req_t in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output ssis_pkg::ssis_rsp_t out_rsp
);
  import ssis_pkg::*;

  ssis_mem_req_t       mem_req;
  logic [KEY_BITS-1:0] rd_data;

  // sequencer: search, shift, key write and result register
  ssis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // ascending key array
  ssis_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ===== tb/sorted_set_insert_search_core_tb.sv =====
// Self-checking testbench for sorted_set_insert_search_core.
// Depends on ssis_pkg and the core RTL; checks every response against an
// in-bench sorted-array predictor.
`timescale 1ns / 1ps

module sorted_set_insert_search_core_tb;
  import ssis_pkg::*;

  // Cycles with no accepted request or response before giving up.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 1100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  ssis_req_t in_req;
  logic      out_valid;
  logic      out_ready;
  ssis_rsp_t out_rsp;

  sorted_set_insert_search_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predictor state: ascending keys below key_count, plus the count itself.
  logic [KEY_BITS-1:0] key_store [DEPTH];
  int                  key_count;

  ssis_rsp_t rsp_expected [$];
  ssis_rsp_t exp_rsp;
  int        errors = 0;
  int        rsp_seen = 0;
  int        idle_cycles = 0;
  bit        idle_en;

  // Receiver-side stall bookkeeping.
  int rx_hold = 0;
  int rx_burst = 0;
  bit hold_done = 1'b0;

  // Directed table: typed rows carry a hand-written response.
  typedef struct {
    ssis_req_t req;
    bit        typed;
    ssis_rsp_t rsp;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Binary search over the stored keys, then the insert or lookup outcome.
  // Updates the predictor state on a successful insert.
  function automatic ssis_rsp_t predict_rsp(input ssis_req_t r);
    int        lo;
    int        hi;
    int        mid;
    int        slot;
    bit        hit;
    ssis_rsp_t o;
    lo   = 0;
    hi   = key_count;
    hit  = 1'b0;
    slot = 0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (key_store[mid] == r.key) begin
        hit  = 1'b1;
        slot = mid;
      end else if (key_store[mid] < r.key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (!hit) slot = lo;
    o.position = '0;
    if (r.action == ACT_SEARCH) begin
      o.status = hit ? ST_FOUND : ST_NOT_FOUND;
      if (hit) o.position = POS_BITS'(slot);
    end else if (hit) begin
      o.status = ST_DUPLICATE;
    end else if (key_count >= DEPTH) begin
      o.status = ST_FULL;
    end else begin
      for (int i = key_count; i > slot; i--) key_store[i] = key_store[i-1];
      key_store[slot] = r.key;
      key_count++;
      o.status   = ST_INSERTED;
      o.position = POS_BITS'(slot);
    end
    o.count = CNT_BITS'(key_count);
    return o;
  endfunction

  function automatic ssis_req_t mk_req(input logic act, input logic [KEY_BITS-1:0] k);
    ssis_req_t r;
    r.action = act;
    r.key    = k;
    return r;
  endfunction

  function automatic ssis_rsp_t mk_rsp(input ssis_status_t st, input int pos, input int cnt);
    ssis_rsp_t o;
    o.status   = st;
    o.position = POS_BITS'(pos);
    o.count    = CNT_BITS'(cnt);
    return o;
  endfunction

  function automatic void add_row(input logic act, input logic [KEY_BITS-1:0] k,
                                  input bit typed, input ssis_rsp_t rsp);
    dir_row_t row;
    row.req   = mk_req(act, k);
    row.typed = typed;
    row.rsp   = rsp;
    dir_rows.push_back(row);
  endfunction

  // A key already in the store, or a random one while the store is empty.
  function automatic logic [KEY_BITS-1:0] stored_key();
    if (key_count == 0) return KEY_BITS'($urandom);
    return key_store[$urandom_range(0, key_count - 1)];
  endfunction

  // Offer one request, after an optional idle burst, and hold it until taken.
  // The expected response is queued at the edge where the request is accepted.
  task automatic send_req(input ssis_req_t r, input bit typed, input ssis_rsp_t typed_rsp);
    int        gap;
    ssis_rsp_t p;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    p = predict_rsp(r);
    rsp_expected.push_back(typed ? typed_rsp : p);
  endtask

  // Receiver: random ready bursts, plus one long hold-off once a few dozen
  // responses have come, so the core fills its output register and stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_done && rsp_seen >= 40) begin
      hold_done = 1'b1;
      rx_hold   = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_burst > 0) begin
      rx_burst--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      rx_burst = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Response checker: field-by-field against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      rsp_seen++;
      if (rsp_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected response status=%0d position=%0d count=%0d",
                 $time, out_rsp.status, out_rsp.position, out_rsp.count);
      end else begin
        exp_rsp = rsp_expected.pop_front();
        if (out_rsp.status !== exp_rsp.status) begin
          errors++;
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, exp_rsp.status, out_rsp.status);
        end
        if (out_rsp.position !== exp_rsp.position) begin
          errors++;
          $display("%0t: position mismatch expected %0d actual %0d",
                   $time, exp_rsp.position, out_rsp.position);
        end
        if (out_rsp.count !== exp_rsp.count) begin
          errors++;
          $display("%0t: count mismatch expected %0d actual %0d",
                   $time, exp_rsp.count, out_rsp.count);
        end
      end
    end
  end

  // Watchdog: any accepted request or response restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sorted_set_insert_search_core_tb failed");
      $finish;
    end
  end

  initial begin
    int                  sel;
    ssis_rsp_t           none;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req      = '0;
    idle_en     = 1'b0;
    key_count   = 0;
    none        = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, key extremes, duplicates, hits and misses.
    add_row(ACT_SEARCH, 16'h0000, 1'b1, mk_rsp(ST_NOT_FOUND, 0, 0));
    add_row(ACT_INSERT, 16'hFFFF, 1'b1, mk_rsp(ST_INSERTED, 0, 1));
    add_row(ACT_INSERT, 16'h0000, 1'b1, mk_rsp(ST_INSERTED, 0, 2));
    add_row(ACT_INSERT, 16'hFFFF, 1'b1, mk_rsp(ST_DUPLICATE, 0, 2));
    add_row(ACT_INSERT, 16'h0000, 1'b1, mk_rsp(ST_DUPLICATE, 0, 2));
    add_row(ACT_SEARCH, 16'h0000, 1'b1, mk_rsp(ST_FOUND, 0, 2));
    add_row(ACT_SEARCH, 16'hFFFF, 1'b1, mk_rsp(ST_FOUND, 1, 2));
    add_row(ACT_SEARCH, 16'h8000, 1'b1, mk_rsp(ST_NOT_FOUND, 0, 2));
    add_row(ACT_INSERT, 16'h5555, 1'b0, none);
    add_row(ACT_INSERT, 16'hAAAA, 1'b0, none);
    add_row(ACT_INSERT, 16'h0001, 1'b0, none);
    add_row(ACT_INSERT, 16'hFFFE, 1'b0, none);
    add_row(ACT_INSERT, 16'h7FFF, 1'b0, none);
    add_row(ACT_SEARCH, 16'h5555, 1'b0, none);
    add_row(ACT_SEARCH, 16'hAAAB, 1'b0, none);
    add_row(ACT_SEARCH, 16'h0001, 1'b0, none);
    add_row(ACT_INSERT, 16'h3333, 1'b0, none);
    add_row(ACT_INSERT, 16'h5555, 1'b0, none);
    add_row(ACT_SEARCH, 16'hFFFE, 1'b0, none);
    add_row(ACT_SEARCH, 16'h7FFE, 1'b0, none);
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    // Growth phase: mostly new keys in the lower half, so later inserts from the
    // full key range land both between and above the stored ones.
    for (int n = 0; n < 350; n++) begin
      idle_en = (n % 120) < 80;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_req(mk_req(ACT_INSERT, KEY_BITS'($urandom_range(0, 16'h7FFF))), 1'b0, none);
      end else if (sel < 55) begin
        send_req(mk_req(ACT_INSERT, stored_key() + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF)),
                 1'b0, none);
      end else if (sel < 65) begin
        send_req(mk_req(ACT_INSERT, stored_key()), 1'b0, none);
      end else if (sel < 85) begin
        send_req(mk_req(ACT_SEARCH, stored_key()), 1'b0, none);
      end else begin
        send_req(mk_req(ACT_SEARCH, KEY_BITS'($urandom)), 1'b0, none);
      end
    end

    // Mixed traffic over the full key range; the last stretch runs back to back.
    for (int n = 0; n < 200; n++) begin
      idle_en = (n < 140) && ((n % 70) < 45);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        send_req(mk_req(ACT_INSERT, stored_key()), 1'b0, none);
      end else if (sel < 60) begin
        send_req(mk_req(ACT_INSERT, KEY_BITS'($urandom)), 1'b0, none);
      end else if (sel < 85) begin
        send_req(mk_req(ACT_SEARCH, stored_key()), 1'b0, none);
      end else begin
        send_req(mk_req(ACT_SEARCH, KEY_BITS'($urandom)), 1'b0, none);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    idle_en  = 1'b0;

    // Drain, then leave room for any stray response.
    while (rsp_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("sorted_set_insert_search_core_tb passed");
    end else begin
      $display("sorted_set_insert_search_core_tb failed");
    end
    $finish;
  end

endmodule
